// File: design/x87rs_pkg.sv
// Shared types, codes and float conversion functions for the x87 register stack.
package x87rs_pkg;

  localparam int DEPTH = 8;
  localparam int PTR_W = 3;
  localparam int DATA_W = 64;
  localparam int TAG_W = 16;
  localparam logic [TAG_W-1:0] TAG_RESET = 16'hffff;

  localparam logic [2:0] FN_PUSH_S = 3'd0;
  localparam logic [2:0] FN_PUSH_D = 3'd1;
  localparam logic [2:0] FN_POP_S  = 3'd2;
  localparam logic [2:0] FN_POP_D  = 3'd3;
  localparam logic [2:0] FN_WRITE  = 3'd4;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  function automatic logic [63:0] widen_single(input logic [31:0] s);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [4:0]  lz;
    logic [23:0] nf;
    logic [10:0] dex;
    begin
      ex = s[30:23];
      fr = s[22:0];
      lz = 5'd0;
      for (int k = 22; k >= 0; k--) begin
        if (fr[k] && lz == 5'd0) lz = 5'(23 - k);
      end
      nf = {1'b0, fr} << lz;
      dex = 11'd897 - 11'(lz);
      if (ex == 8'hff) begin
        if (fr == 23'd0) widen_single = {s[31], 63'h7ff0000000000000};
        else widen_single = {s[31], 11'h7ff, 1'b1, fr[21:0], 29'd0};
      end else if (ex == 8'd0) begin
        if (fr == 23'd0) widen_single = {s[31], 63'd0};
        else widen_single = {s[31], dex, nf[22:0], 29'd0};
      end else begin
        widen_single = {s[31], 11'(ex) + 11'd896, fr, 29'd0};
      end
    end
  endfunction

  function automatic logic [31:0] narrow_double(input logic [63:0] d);
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] sig;
    logic [12:0] fe;
    logic [6:0]  sh;
    logic [52:0] q, rem, half, msk;
    logic [7:0]  base;
    logic [31:0] bits;
    begin
      ex = d[62:52];
      fr = d[51:0];
      sig = {1'b1, fr};
      fe = 13'(ex) - 13'd896;
      sh = fe[12] || fe == 13'd0 ? 7'(13'd30 - fe) : 7'd29;
      q = sig >> sh;
      msk = (53'd1 << sh) - 53'd1;
      rem = sig & msk;
      half = 53'd1 << (sh - 7'd1);
      if (rem > half || (rem == half && q[0])) q = q + 53'd1;
      base = (!fe[12] && fe != 13'd0) ? 8'(fe - 13'd1) : 8'd0;
      bits = {1'b0, base, 23'd0} + q[31:0];
      if (bits >= 32'h7f800000) bits = 32'h7f800000;
      if (ex == 11'h7ff) begin
        if (fr == 52'd0) narrow_double = {d[63], 31'h7f800000};
        else narrow_double = {d[63], 8'hff, 1'b1, fr[50:29]};
      end else if (ex == 11'd0) begin
        narrow_double = {d[63], 31'd0};
      end else if (!fe[12] && fe >= 13'd255) begin
        narrow_double = {d[63], 31'h7f800000};
      end else if (fe[12] && (13'd30 - fe) >= 13'd55) begin
        narrow_double = {d[63], 31'd0};
      end else begin
        narrow_double = {d[63], bits[30:0]};
      end
    end
  endfunction

endpackage

// File: design/x87rs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module x87rs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/x87rs_ctrl.sv
// Sequencer: top pointer, tag word, clear sweep, RAM access and result formatting.
module x87rs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_func,
  input  logic [31:0]                 in_mem_address,
  input  logic [63:0]                 in_operand_bits,
  input  logic [2:0]                  in_stack_offset,
  output x87rs_pkg::ram_req_t         ram_req,
  input  logic [63:0]                 ram_rdata,
  output logic                        out_strobe,
  output logic                        out_store_valid,
  output logic                        out_store_is_double,
  output logic [31:0]                 out_store_address,
  output logic [63:0]                 out_store_data,
  output logic [2:0]                  out_top_now,
  output logic [15:0]                 out_tag_now
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  clr_r, clr_nxt;
  logic [2:0]  top_r, top_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [2:0]  func_r;
  logic [31:0] addr_r;
  logic        strobe_r, strobe_nxt;
  logic        sv_r, sv_nxt, sd_r, sd_nxt;
  logic [31:0] sa_r, sa_nxt;
  logic [63:0] sdat_r, sdat_nxt;
  logic [2:0]  idx;
  logic        take;

  assign take = start && state_r == ST_IDLE;
  assign busy = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    top_nxt = top_r;
    tag_nxt = tag_r;
    strobe_nxt = 1'b0;
    sv_nxt = 1'b0;
    sd_nxt = 1'b0;
    sa_nxt = 32'd0;
    sdat_nxt = 64'd0;
    ram_req = '0;
    ram_req.raddr = top_r;
    idx = top_r;
    case (state_r)
      ST_CLEAR: begin
        ram_req.we = 1'b1;
        ram_req.waddr = clr_r[2:0];
        clr_nxt = clr_r + 4'd1;
        if (clr_r == 4'(x87rs_pkg::DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          case (in_func)
            x87rs_pkg::FN_PUSH_S, x87rs_pkg::FN_PUSH_D: begin
              idx = top_r - 3'd1;
              top_nxt = idx;
              ram_req.we = 1'b1;
              ram_req.waddr = idx;
              ram_req.wdata = in_func == x87rs_pkg::FN_PUSH_S
                ? x87rs_pkg::widen_single(in_operand_bits[31:0]) : in_operand_bits;
              tag_nxt = tag_r & ~(16'h3 << {idx, 1'b0});
              strobe_nxt = 1'b1;
            end
            x87rs_pkg::FN_POP_S, x87rs_pkg::FN_POP_D: begin
              state_nxt = ST_READ;
            end
            x87rs_pkg::FN_WRITE: begin
              idx = top_r + in_stack_offset;
              ram_req.we = 1'b1;
              ram_req.waddr = idx;
              ram_req.wdata = in_operand_bits;
              tag_nxt = tag_r & ~(16'h3 << {idx, 1'b0});
              strobe_nxt = 1'b1;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
        strobe_nxt = 1'b1;
        sv_nxt = 1'b1;
        sa_nxt = addr_r;
        top_nxt = top_r + 3'd1;
        if (func_r == x87rs_pkg::FN_POP_D) begin
          sd_nxt = 1'b1;
          sdat_nxt = ram_rdata;
        end else begin
          sdat_nxt = {32'd0, x87rs_pkg::narrow_double(ram_rdata)};
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= 4'd0;
      top_r <= 3'd0;
      tag_r <= x87rs_pkg::TAG_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      top_r <= top_nxt;
      tag_r <= tag_nxt;
      strobe_r <= strobe_nxt;
    end
    if (take) begin
      func_r <= in_func;
      addr_r <= in_mem_address;
    end
    sv_r <= sv_nxt;
    sd_r <= sd_nxt;
    sa_r <= sa_nxt;
    sdat_r <= sdat_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_store_valid = sv_r;
  assign out_store_is_double = sd_r;
  assign out_store_address = sa_r;
  assign out_store_data = sdat_r;
  assign out_top_now = top_r;
  assign out_tag_now = tag_r;

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> strobe_r && state_r == ST_IDLE) else $error("pop lost");
  a_pop_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> top_r == $past(top_r) + 3'd1) else $error("pop top");
  a_store_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> strobe_r) else $error("store without strobe");
endmodule

// File: design/x87_register_stack_load_store_top.sv
// Top level of the x87 register stack load/store block.
// Usage: drive in_func, in_mem_address, in_operand_bits and in_stack_offset with
// start high; the item is taken at an edge where busy is low.
// Each item gives one result, shown for one cycle with out_strobe high.
// Pushes, relative writes and unused codes: result in the cycle after accept,
// next item may follow at once (one item per cycle).
// Pop-stores: the stack RAM read is registered, so the result is formed in the
// read state and then registered; busy stays high until the read is done.
// Reset: synchronous, rst_n low. After it, busy stays high while a clearing
// pass zeroes the eight stack entries; top is 0, tag word all ones.
// The receiver cannot stall: every result must be taken in its strobe cycle.
module x87_register_stack_load_store_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_mem_address,
  input  logic [63:0] in_operand_bits,
  input  logic [2:0]  in_stack_offset,
  output logic        out_strobe,
  output logic        out_store_valid,
  output logic        out_store_is_double,
  output logic [31:0] out_store_address,
  output logic [63:0] out_store_data,
  output logic [2:0]  out_top_now,
  output logic [15:0] out_tag_now
);
  x87rs_pkg::ram_req_t ram_req;
  logic [63:0]         ram_rdata;

  x87rs_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy,
    .in_func, .in_mem_address, .in_operand_bits, .in_stack_offset,
    .ram_req, .ram_rdata,
    .out_strobe, .out_store_valid, .out_store_is_double, .out_store_address,
    .out_store_data, .out_top_now, .out_tag_now
  );

  x87rs_ram #(.WIDTH(x87rs_pkg::DATA_W), .DEPTH(x87rs_pkg::DEPTH)) u_ram (
    .clk,
    .we(ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );
endmodule
